>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file rev_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define REV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define REV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/rev_pkg.sv
// ----------------------------------------------------------------------------
// rev_pkg
// Shared types and constants of the rotary encoder velocity block.
// ----------------------------------------------------------------------------
`default_nettype none

package rev_pkg;

  localparam int unsigned MS_PER_SEC   = 1000;
  localparam int unsigned VEL_CLEAR_MS = 1000;
  localparam int unsigned QUO_W        = $clog2(MS_PER_SEC + 1);
  localparam int unsigned DIV_CNT_W    = $clog2(QUO_W);
  localparam int unsigned LIMIT_W      = 16;
  localparam int unsigned SPEED_W      = 11;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned NOW_W        = 32;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned CFG_ADDR_W   = 2;

  localparam logic [LIMIT_W-1:0] SLOW_RST = 16'd2;
  localparam logic [LIMIT_W-1:0] FAST_RST = 16'd8;
  localparam logic [LIMIT_W-1:0] IDLE_RST = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SLOW_LIMIT = 2'd0,
    CFG_FAST_LIMIT = 2'd1,
    CFG_IDLE_LIMIT = 2'd2
  } rev_cfg_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_GAP    = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_DONE   = 6'b100000
  } rev_state_e;

  typedef struct packed {
    logic load;
    logic gap_en;
    logic decide;
    logic div_start;
    logic div_step;
    logic commit;
    logic out_load;
  } rev_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } rev_sts_t;

endpackage

`default_nettype wire

>>> sv/rev_div.sv
// ----------------------------------------------------------------------------
// rev_div
// Restoring divider: one quotient bit per step of MS_PER_SEC / divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rev_div import rev_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               step_i,
  input  logic [LIMIT_W-1:0] den_i,
  output logic [QUO_W-1:0]   quo_o,
  output logic               last_o
);

  logic [LIMIT_W-1:0]   rem_q, rem_d;
  logic [LIMIT_W-1:0]   den_q;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [LIMIT_W:0]     rem_sh;
  logic [LIMIT_W+1:0]   diff;

  assign rem_sh = {rem_q, quo_q[QUO_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = QUO_W'(MS_PER_SEC);
      cnt_d = '0;
    end else if (step_i) begin
      if (!diff[LIMIT_W+1]) begin
        rem_d = diff[LIMIT_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[LIMIT_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o  = quo_q;
  assign last_o = (cnt_q == DIV_CNT_W'(QUO_W - 1));

endmodule

`default_nettype wire

>>> sv/rev_datapath.sv
// ----------------------------------------------------------------------------
// rev_datapath
// Sample registers, click state, limits, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rev_datapath import rev_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [LIMIT_W-1:0]     cfg_data_i,
  input  rev_cmd_t               cmd_i,
  output rev_sts_t               sts_o,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic [LIMIT_W-1:0]     slow_q, fast_q, idle_q;
  logic                   a_q, b_q;
  logic [TIME_WIDTH-1:0]  now_q, gap_q, last_q;
  logic                   detent_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [SPEED_W-1:0]     speed_q;
  logic [OUT_TDATA_W-1:0] out_q;

  logic [TIME_WIDTH+NOW_W-1:0]  now_ext;
  logic [TIME_WIDTH+15:0]       gap_ext;
  logic [COUNT_WIDTH+POS_W-1:0] cnt_ext;
  logic                         gap_fits;
  logic                         click;
  logic                         cw;
  logic [LIMIT_W-1:0]           den;
  logic [QUO_W-1:0]             quo;
  logic                         div_last;
  logic [SPEED_W-1:0]           mag_pos;
  logic [SPEED_W-1:0]           mag;
  logic [LIMIT_W-1:0]           mag_ext;
  logic                         turning;

  assign now_ext  = {{TIME_WIDTH{1'b0}}, in_data_i[NOW_W+1:2]};
  assign gap_ext  = {16'd0, gap_q};
  assign gap_fits = ((gap_ext >> 16) == '0);

  assign click    = detent_q && (a_q != b_q);
  assign cw       = !a_q && b_q;
  assign den      = (gap_q[LIMIT_W-1:0] == '0) ? LIMIT_W'(1) : gap_q[LIMIT_W-1:0];

  assign sts_o.need_div = click && (last_q != '0) && gap_fits
                          && (gap_q[LIMIT_W-1:0] <= idle_q);
  assign sts_o.div_last = div_last;

  rev_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .step_i  (cmd_i.div_step),
    .den_i   (den),
    .quo_o   (quo),
    .last_o  (div_last)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q <= SLOW_RST;
      fast_q <= FAST_RST;
      idle_q <= IDLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SLOW_LIMIT: slow_q <= cfg_data_i;
        CFG_FAST_LIMIT: fast_q <= cfg_data_i;
        CFG_IDLE_LIMIT: idle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Click state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      detent_q <= 1'b0;
      count_q  <= '0;
      speed_q  <= '0;
    end else begin
      if (cmd_i.decide) begin
        if (click) begin
          last_q   <= now_q;
          detent_q <= 1'b0;
        end else begin
          if (a_q && b_q) begin
            detent_q <= 1'b1;
          end
          if (gap_q >= TIME_WIDTH'(VEL_CLEAR_MS)) begin
            speed_q <= '0;
          end
        end
      end
      if (cmd_i.commit) begin
        if (cw) begin
          count_q <= count_q + COUNT_WIDTH'(1);
          speed_q <= {1'b0, quo};
        end else begin
          count_q <= count_q - COUNT_WIDTH'(1);
          speed_q <= ~{1'b0, quo} + SPEED_W'(1);
        end
      end
    end
  end

  // Result flags from the updated velocity
  assign mag_pos = ~speed_q + SPEED_W'(1);
  assign mag     = speed_q[SPEED_W-1] ? mag_pos : speed_q;
  assign mag_ext = {{(LIMIT_W-SPEED_W){1'b0}}, mag};
  assign turning = (speed_q != '0);
  assign cnt_ext = {{POS_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= in_data_i[0];
      b_q   <= in_data_i[1];
      now_q <= now_ext[TIME_WIDTH-1:0];
    end
    if (cmd_i.gap_en) begin
      gap_q <= now_q - last_q;
    end
    if (cmd_i.out_load) begin
      out_q <= {7'd0,
                turning && (mag_ext > fast_q),
                turning && (mag_ext >= slow_q) && (mag_ext <= fast_q),
                turning && (mag_ext < slow_q),
                speed_q[SPEED_W-1],
                turning && !speed_q[SPEED_W-1],
                turning,
                speed_q,
                cnt_ext[POS_W-1:0]};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> sv/rev_ctrl.sv
// ----------------------------------------------------------------------------
// rev_ctrl
// Sequencer for one sample: gap, decision, optional divide, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rev_ctrl import rev_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rev_sts_t sts_i,
  output rev_cmd_t cmd_o
);

  rev_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_GAP;
        end
      end
      ST_GAP: begin
        cmd_o.gap_en = 1'b1;
        state_d      = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide    = 1'b1;
        cmd_o.div_start = sts_i.need_div;
        state_d         = sts_i.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // Result register free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/rotary_encoder_velocity.sv
// ----------------------------------------------------------------------------
// rotary_encoder_velocity
// Quadrature encoder click decoder with position counter and click velocity.
// ----------------------------------------------------------------------------
// Each input transaction is one sample of lines A and B with a millisecond
// time stamp and yields exactly one output transaction with the position,
// signed velocity (clicks per second) and turning/speed flags after that
// sample. A sample that is not a timed click skips the divider, while a
// timed click also goes through the 10-step restoring divider that
// forms 1000 / gap one quotient bit per cycle. The result sits in an output
// register, so the next sample is taken while a result waits downstream.
// Limits are written through the cfg port (index 0 slow, 1 fast, 2 idle),
// which is always ready and should be used only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_velocity import rev_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [0] line_a, [1] line_b, [33:2] now_ms, [39:34] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [15:0] position, [26:16] velocity, [27] turning, [28] turning_cw,
  // [29] turning_ccw, [30] is_slow, [31] is_medium, [32] is_fast, [39:33] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [LIMIT_W-1:0]     cfg_data_i
);

  rev_cmd_t cmd;
  rev_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rev_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rev_datapath #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

>>> sv/rev_checker.sv
// ----------------------------------------------------------------------------
// rev_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rev_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_o
);

  `REV_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

  `REV_ASSERT(a_stall_holds, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  `REV_ASSERT(a_dir_flags, m_axis_tvalid_o |-> (m_axis_tdata_o[27] == (m_axis_tdata_o[26:16] != 11'd0)) && (m_axis_tdata_o[29] == m_axis_tdata_o[26]) && (m_axis_tdata_o[28] == (m_axis_tdata_o[27] && !m_axis_tdata_o[26])), "direction flags disagree with velocity")

  `REV_ASSERT(a_no_class_idle, m_axis_tvalid_o && !m_axis_tdata_o[27] |-> m_axis_tdata_o[32:30] == 3'b000, "speed class set while idle")

  `REV_ASSERT(a_vel_range, m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[26:16]) <= 11'sd1000) && ($signed(m_axis_tdata_o[26:16]) >= -11'sd1000), "velocity out of range")

endmodule

bind rotary_encoder_velocity rev_checker u_rev_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
